// ===== sv/pefe_pkg.sv =====
// Shared types and constants of the pair-escaping frame encoder.
package pefe_pkg;

	localparam logic [7:0] HDR_BYTE = 8'h7B;
	localparam logic [7:0] TRL_BYTE = 8'h7D;
	localparam logic [7:0] ESC_BYTE = 8'h1B;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic       hdr;
		logic       esc;
		logic       emit_prev;
		logic       last;
		logic [7:0] prev;
		logic [7:0] cur;
	} cmd_t;

endpackage

// ===== sv/pefe_front.sv =====
// Front end: accepts payload bytes, finds escaped pairs and issues commands.
module pefe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // data_byte[7:0]
	input  logic             s_tlast,   // frame_end
	output logic             q_push,
	output pefe_pkg::cmd_t   q_wdata,
	input  logic             q_full
);
	import pefe_pkg::*;

	logic       in_frame_q;
	logic       held_valid_q;
	logic [7:0] held_byte_q;
	logic       accept;
	logic       esc;

	always_comb begin
		s_tready = !q_full;
		accept   = s_tvalid && s_tready;
		esc      = held_valid_q && (held_byte_q == s_tdata)
		           && ((s_tdata == HDR_BYTE) || (s_tdata == TRL_BYTE));
		q_wdata.hdr       = !in_frame_q;
		q_wdata.esc       = esc;
		q_wdata.emit_prev = held_valid_q && !esc;
		q_wdata.last      = s_tlast;
		q_wdata.prev      = held_byte_q;
		q_wdata.cur       = s_tdata;
		q_push = accept && (q_wdata.hdr || q_wdata.esc || q_wdata.emit_prev || q_wdata.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			in_frame_q   <= !s_tlast;
			held_valid_q <= !s_tlast && !esc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !esc) begin
			held_byte_q <= s_tdata;
		end
	end

endmodule

// ===== sv/pefe_queue.sv =====
// Two-entry command queue between the front end and the byte sequencer.
module pefe_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pefe_pkg::cmd_t   wdata,
	output logic             full,
	input  logic             pop,
	output pefe_pkg::cmd_t   rdata,
	output logic             empty
);
	import pefe_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		full    = (count_q == CNT_W'(QUEUE_DEPTH));
		empty   = (count_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		rdata   = entry_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== sv/pefe_back.sv =====
// Back end: expands each command into output bytes, one byte per cycle while m_tready allows.
module pefe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  pefe_pkg::cmd_t   q_rdata,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // out_byte[7:0]
	output logic             m_tlast    // frame_done
);
	import pefe_pkg::*;

	localparam int NUM_SLOTS = 10;
	localparam int SLOT_HDR0 = 0;
	localparam int SLOT_HDR1 = 1;
	localparam int SLOT_ESC0 = 2;
	localparam int SLOT_ESC1 = 3;
	localparam int SLOT_PAIR0 = 4;
	localparam int SLOT_PAIR1 = 5;
	localparam int SLOT_PREV = 6;
	localparam int SLOT_FLUSH = 7;
	localparam int SLOT_TRL0 = 8;
	localparam int SLOT_TRL1 = 9;

	logic [NUM_SLOTS-1:0] mask_q;
	logic [7:0]           prev_q;
	logic [7:0]           cur_q;
	logic                 m_valid_q;
	logic [7:0]           m_data_q;
	logic                 m_last_q;
	logic [NUM_SLOTS-1:0] low;
	logic [NUM_SLOTS-1:0] rest;
	logic [NUM_SLOTS-1:0] new_mask;
	logic                 adv;
	logic                 emit;
	logic                 load;
	logic [7:0]           sel_byte;

	function automatic logic [7:0] slot_byte(input int idx, input logic [7:0] prev,
		input logic [7:0] cur);
		logic [7:0] b;
		b = TRL_BYTE;
		if (idx == SLOT_HDR0 || idx == SLOT_HDR1) begin
			b = HDR_BYTE;
		end else if (idx == SLOT_ESC0 || idx == SLOT_ESC1) begin
			b = ESC_BYTE;
		end else if (idx == SLOT_PAIR0 || idx == SLOT_PAIR1 || idx == SLOT_FLUSH) begin
			b = cur;
		end else if (idx == SLOT_PREV) begin
			b = prev;
		end
		return b;
	endfunction

	always_comb begin
		new_mask = '0;
		new_mask[SLOT_HDR0]  = q_rdata.hdr;
		new_mask[SLOT_HDR1]  = q_rdata.hdr;
		new_mask[SLOT_ESC0]  = q_rdata.esc;
		new_mask[SLOT_ESC1]  = q_rdata.esc;
		new_mask[SLOT_PAIR0] = q_rdata.esc;
		new_mask[SLOT_PAIR1] = q_rdata.esc;
		new_mask[SLOT_PREV]  = q_rdata.emit_prev && !q_rdata.esc;
		new_mask[SLOT_FLUSH] = q_rdata.last && !q_rdata.esc;
		new_mask[SLOT_TRL0]  = q_rdata.last;
		new_mask[SLOT_TRL1]  = q_rdata.last;

		low  = mask_q & (~mask_q + 1'b1);
		rest = mask_q & ~low;
		adv  = !m_valid_q || m_tready;
		emit = adv && (mask_q != '0);
		load = (mask_q == '0) || (emit && (rest == '0));
		q_pop = load && !q_empty;

		sel_byte = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (low[i]) begin
				sel_byte = sel_byte | slot_byte(i, prev_q, cur_q);
			end
		end

		m_tvalid = m_valid_q;
		m_tdata  = m_data_q;
		m_tlast  = m_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= q_empty ? '0 : new_mask;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
				m_last_q  <= low[SLOT_TRL1];
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prev_q <= q_rdata.prev;
			cur_q  <= q_rdata.cur;
		end
		if (emit) begin
			m_data_q <= sel_byte;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_last_q |-> m_data_q == TRL_BYTE)
		else $error("frame_done set on a byte that is not the trailer");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (mask_q == '0) || (emit && $countones(mask_q) == 1))
		else $error("command loaded while the current one still has bytes");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_valid_q && (m_data_q == $past(sel_byte)))
		else $error("emitted byte did not reach the output register");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> mask_q != '0)
		else $error("loaded command produced no output bytes");

endmodule

// ===== sv/pair_escape_frame_encoder_core.sv =====
// Top level of the pair-escaping frame encoder.
// Each frame leaves as the header 7B 7B, the payload with every 7B 7B or 7D 7D pair
// sent as 1B 1B and the pair, and the trailer 7D 7D with tlast on its last byte. The
// output moves one byte per cycle while m_tready allows, and a request causes zero to
// six output bytes. A two-entry command queue lies between the input side and the byte
// sequencer, so input requests keep being taken while output bytes wait for m_tready,
// until the queue is full. A byte is held back until the next one shows whether it
// starts a pair; the request with tlast releases it.
module pair_escape_frame_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte[7:0]
	input  logic       s_tlast,   // frame_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte[7:0]
	output logic       m_tlast    // frame_done
);
	import pefe_pkg::*;

	cmd_t q_wdata;
	cmd_t q_rdata;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	pefe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_push   (q_push),
		.q_wdata  (q_wdata),
		.q_full   (q_full)
	);

	pefe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	pefe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the pair-escaping frame encoder core.
`timescale 1ns / 1ps

module tb;
	import pefe_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_REQUESTS = 300;
	localparam int HOLD_CYCLES = 150;
	localparam int BURST_REQUESTS = 24;
	localparam int DRAIN_CYCLES = 20;
	localparam int STUCK_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_done;
	} enc_byte_t;

	class frame_scoreboard;
		enc_byte_t pending_bytes[$];
		bit in_frame = 1'b0;
		bit held_valid = 1'b0;
		logic [7:0] held_byte = 8'h00;
		int mismatches = 0;
		int requests_seen = 0;
		int bytes_seen = 0;
		int frames_seen = 0;
		int pairs_seen = 0;

		function void push_byte(logic [7:0] b, logic done);
			enc_byte_t e;
			e.out_byte = b;
			e.frame_done = done;
			pending_bytes.push_back(e);
		endfunction

		// Works out the bytes that one accepted payload request must produce.
		function void encode_request(logic [7:0] b, logic last);
			requests_seen++;
			if (!in_frame) begin
				push_byte(HDR_BYTE, 1'b0);
				push_byte(HDR_BYTE, 1'b0);
				in_frame = 1'b1;
			end
			if (held_valid && held_byte == b && (b == HDR_BYTE || b == TRL_BYTE)) begin
				push_byte(ESC_BYTE, 1'b0);
				push_byte(ESC_BYTE, 1'b0);
				push_byte(b, 1'b0);
				push_byte(b, 1'b0);
				held_valid = 1'b0;
				pairs_seen++;
			end else begin
				if (held_valid)
					push_byte(held_byte, 1'b0);
				held_byte = b;
				held_valid = 1'b1;
			end
			if (last) begin
				if (held_valid)
					push_byte(held_byte, 1'b0);
				held_valid = 1'b0;
				push_byte(TRL_BYTE, 1'b0);
				push_byte(TRL_BYTE, 1'b1);
				in_frame = 1'b0;
				frames_seen++;
			end
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("MISMATCH at %0t: %s", $realtime, what);
		endfunction

		function void check_byte(logic [7:0] b, logic done);
			enc_byte_t exp_b;
			bytes_seen++;
			if (pending_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h tlast %0b, none expected", b, done));
			end else begin
				exp_b = pending_bytes.pop_front();
				if (b !== exp_b.out_byte || done !== exp_b.frame_done)
					report($sformatf("byte %0d: expected %02h tlast %0b, got %02h tlast %0b",
						bytes_seen, exp_b.out_byte, exp_b.frame_done, b, done));
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	frame_scoreboard sb = new;
	logic [7:0] frame_q[$];
	int requests_sent = 0;
	int stuck_cycles = 0;
	bit no_idle = 1'b0;
	bit sender_burst = 1'b0;
	bit hold_off = 1'b0;
	bit hold_done = 1'b0;

	pair_escape_frame_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || sender_burst)
			return 0;
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Biased toward the marker bytes so that pairs and runs of them are common.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return HDR_BYTE;
		if (r < 6)
			return TRL_BYTE;
		if (r == 6)
			return ESC_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_request(input logic [7:0] b, input logic last);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		requests_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_request(frame_q[i], i == frame_q.size() - 1);
	endtask

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.encode_request(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_byte(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Timeout: no request moved for %0d cycles.", STUCK_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int r;
		wait (arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
				hold_done = 1'b1;
			end else if (no_idle) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end else begin
					m_tready <= 1'b0;
					if (r < 92)
						repeat ($urandom_range(1, 3)) @(posedge clk);
					else
						repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int len;
		int directed_count;
		int burst_end;
		bit noise;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-byte frames, escaped pairs at the end, runs of three and four, held bytes.
		frame_q = {HDR_BYTE};
		send_frame();
		frame_q = {8'h00};
		send_frame();
		frame_q = {8'hFF, HDR_BYTE, HDR_BYTE};
		send_frame();
		frame_q = {TRL_BYTE, TRL_BYTE, TRL_BYTE};
		send_frame();
		frame_q = {HDR_BYTE, HDR_BYTE, HDR_BYTE, HDR_BYTE};
		send_frame();
		frame_q = {HDR_BYTE, TRL_BYTE, ESC_BYTE, ESC_BYTE, TRL_BYTE};
		send_frame();
		frame_q = {TRL_BYTE, TRL_BYTE, 8'h55};
		send_frame();
		directed_count = requests_sent;
		burst_end = 0;

		while (requests_sent < directed_count + RANDOM_REQUESTS) begin
			if (!hold_done && !sender_burst && requests_sent >= directed_count + 100) begin
				hold_off = 1'b1;
				sender_burst = 1'b1;
				burst_end = requests_sent + BURST_REQUESTS;
			end
			if (sender_burst && requests_sent >= burst_end)
				sender_burst = 1'b0;
			no_idle = (requests_sent >= directed_count + 200 &&
				requests_sent < directed_count + 240);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
			noise = ($urandom_range(0, 3) == 0);
			frame_q = {};
			for (int i = 0; i < len; i++)
				frame_q.push_back(noise ? 8'($urandom_range(0, 255)) : pick_byte());
			send_frame();
		end
		s_tvalid <= 1'b0;
		sender_burst = 1'b0;
		no_idle = 1'b0;

		while (sb.pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d payload requests in %0d frames; checked %0d output bytes.",
			sb.requests_seen, sb.frames_seen, sb.bytes_seen);
		$display("Escaped pairs: %0d; long receiver hold-off with the input side stalled: %0b.",
			sb.pairs_seen, hold_done);
		if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d bytes still expected.", sb.mismatches,
				sb.pending_bytes.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pefe_pkg.sv
sv/pefe_front.sv
sv/pefe_queue.sv
sv/pefe_back.sv
sv/pair_escape_frame_encoder_core.sv
test/tb.sv
